// File: design/sha1_message_digest_core_assert.svh
// assertion macros used by the sha-1 digest controller
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA1MD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SHA1MD_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SHA1MD_ASSERT(lbl, clk, rst_n, prop, msg)
`define SHA1MD_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: design/sha1md_pkg.sv
// types and constants shared by the sha-1 digest core
package sha1md_pkg;

    localparam int unsigned ChainWords = 5;
    localparam int unsigned SchedWords = 16;
    localparam logic [6:0]  RoundLast  = 7'd79;
    localparam logic [2:0]  LastWord   = 3'd4;
    localparam logic [7:0]  PadByte    = 8'h80;

    localparam logic [31:0] ChainInit [ChainWords] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    localparam logic [31:0] RoundK0 = 32'h5A827999;
    localparam logic [31:0] RoundK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RoundK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RoundK3 = 32'hCA62C1D6;

    typedef enum logic [1:0] {
        SEL_MSG,
        SEL_PAD,
        SEL_ZERO,
        SEL_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      byte_we;
        t_byte_sel byte_sel;
        logic      round_load;
        logic      round_en;
        logic [6:0] round_idx;
        logic      chain_add;
        logic      chain_init;
    } t_cmd;

    typedef struct packed {
        logic [5:0] pos;
    } t_stat;

endpackage

// File: design/sha1md_dp.sv
// sha-1 datapath: byte packing, message schedule, round unit and chaining words
module sha1md_dp
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [7:0]  i_data_byte,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_word_sel,
    output t_stat       o_stat,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_chain [ChainWords];
    logic [31:0] r_sched [SchedWords];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [23:0] r_acc;
    logic [63:0] r_count;
    logic [5:0]  r_pos;

    logic [7:0]  byte_val;
    logic [63:0] bit_len;
    logic [2:0]  len_sel;
    logic [31:0] sched_mix;
    logic [31:0] round_w;
    logic [31:0] round_f;
    logic [31:0] round_k;
    logic [31:0] round_t;
    logic        sched_shift;

    // message length in bits, big-endian byte for the current position
    assign bit_len = {r_count[60:0], 3'b000};
    assign len_sel = 3'd7 - r_pos[2:0];

    always_comb begin
        case (i_cmd.byte_sel)
            SEL_MSG:  byte_val = i_data_byte;
            SEL_PAD:  byte_val = PadByte;
            SEL_LEN:  byte_val = bit_len[{len_sel, 3'b000} +: 8];
            default:  byte_val = 8'h00;
        endcase
    end

    assign sched_mix = r_sched[13] ^ r_sched[8] ^ r_sched[2] ^ r_sched[0];
    assign round_w   = (i_cmd.round_idx < 7'd16) ? r_sched[0]
                                                 : {sched_mix[30:0], sched_mix[31]};

    always_comb begin
        if (i_cmd.round_idx < 7'd20) begin
            round_f = (r_b & r_c) | (~r_b & r_d);
            round_k = RoundK0;
        end else if (i_cmd.round_idx < 7'd40) begin
            round_f = r_b ^ r_c ^ r_d;
            round_k = RoundK1;
        end else if (i_cmd.round_idx < 7'd60) begin
            round_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            round_k = RoundK2;
        end else begin
            round_f = r_b ^ r_c ^ r_d;
            round_k = RoundK3;
        end
    end

    assign round_t = {r_a[26:0], r_a[31:27]} + round_f + r_e + round_k + round_w;

    // a full word enters the schedule line, or a round consumes one
    assign sched_shift = (i_cmd.byte_we && (r_pos[1:0] == 2'd3)) || i_cmd.round_en;

    always_ff @(posedge i_clk) begin
        if (sched_shift) begin
            for (int i = 0; i < SchedWords - 1; i++) begin
                r_sched[i] <= r_sched[i + 1];
            end
            r_sched[SchedWords - 1] <= i_cmd.round_en ? round_w : {r_acc, byte_val};
        end
        if (i_cmd.byte_we) begin
            r_acc <= {r_acc[15:0], byte_val};
        end
        if (i_cmd.round_load) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (i_cmd.round_en) begin
            r_a <= round_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.chain_init) begin
            for (int i = 0; i < ChainWords; i++) begin
                r_chain[i] <= ChainInit[i];
            end
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.chain_add) begin
                r_chain[0] <= r_chain[0] + r_a;
                r_chain[1] <= r_chain[1] + r_b;
                r_chain[2] <= r_chain[2] + r_c;
                r_chain[3] <= r_chain[3] + r_d;
                r_chain[4] <= r_chain[4] + r_e;
            end
            if (i_cmd.byte_we) begin
                r_pos <= r_pos + 6'd1;
                if (i_cmd.byte_sel == SEL_MSG) begin
                    r_count <= r_count + 64'd1;
                end
            end
        end
    end

    assign o_stat.pos = r_pos;

    always_comb begin
        case (i_word_sel)
            3'd0:    o_digest_word = r_chain[0];
            3'd1:    o_digest_word = r_chain[1];
            3'd2:    o_digest_word = r_chain[2];
            3'd3:    o_digest_word = r_chain[3];
            3'd4:    o_digest_word = r_chain[4];
            default: o_digest_word = r_chain[0];
        endcase
    end

endmodule

// File: design/sha1md_ctrl.sv
// sha-1 controller: request handshakes, padding sequence, round count and digest readout
`include "sha1_message_digest_core_assert.svh"
module sha1md_ctrl
    import sha1md_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_byte_present,
    input  logic       i_end_of_message,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    input  t_stat      i_stat,
    output t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_FILL,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    logic [6:0] r_round, n_round;
    logic [2:0] r_idx, n_idx;
    logic       r_end, n_end;
    logic       r_padding, n_padding;
    logic       r_len_blk, n_len_blk;
    logic       blk_full;
    logic       len_area;

    assign blk_full = (i_stat.pos == 6'd63);
    assign len_area = (i_stat.pos[5:3] == 3'd7);

    always_comb begin
        n_state   = r_state;
        n_round   = r_round;
        n_idx     = r_idx;
        n_end     = r_end;
        n_padding = r_padding;
        n_len_blk = r_len_blk;

        o_cmd            = '0;
        o_cmd.byte_sel   = SEL_MSG;
        o_cmd.round_idx  = r_round;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_end     = i_end_of_message;
                    n_padding = 1'b0;
                    n_len_blk = 1'b0;
                    if (i_byte_present) begin
                        o_cmd.byte_we = 1'b1;
                    end
                    if (i_byte_present && blk_full) begin
                        o_cmd.round_load = 1'b1;
                        n_state          = S_ROUND;
                    end else if (i_end_of_message) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                o_cmd.byte_we  = 1'b1;
                o_cmd.byte_sel = SEL_PAD;
                n_padding      = 1'b1;
                // length fits behind the marker only if it lands before the last eight bytes
                n_len_blk      = !len_area;
                if (blk_full) begin
                    o_cmd.round_load = 1'b1;
                    n_state          = S_ROUND;
                end else begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.byte_we  = 1'b1;
                o_cmd.byte_sel = (r_len_blk && len_area) ? SEL_LEN : SEL_ZERO;
                if (blk_full) begin
                    o_cmd.round_load = 1'b1;
                    n_state          = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round_en = 1'b1;
                if (r_round == RoundLast) begin
                    n_round = '0;
                    n_state = S_ADD;
                end else begin
                    n_round = r_round + 7'd1;
                end
            end
            S_ADD: begin
                o_cmd.chain_add = 1'b1;
                if (!r_end) begin
                    n_state = S_IDLE;
                end else if (!r_padding) begin
                    n_state = S_PAD;
                end else if (r_len_blk) begin
                    n_idx   = '0;
                    n_state = S_EMIT;
                end else begin
                    // marker block is done, length goes in a block of its own
                    n_len_blk = 1'b1;
                    n_state   = S_FILL;
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    if (r_idx == LastWord) begin
                        o_cmd.chain_init = 1'b1;
                        n_end            = 1'b0;
                        n_padding        = 1'b0;
                        n_state          = S_IDLE;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_round   <= '0;
            r_idx     <= '0;
            r_end     <= 1'b0;
            r_padding <= 1'b0;
            r_len_blk <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_idx     <= n_idx;
            r_end     <= n_end;
            r_padding <= n_padding;
            r_len_blk <= n_len_blk;
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_EMIT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LastWord);

    `SHA1MD_NEVER(a_ready_and_valid, i_clk, i_rst_n, o_in_ready && o_out_valid, "ready while digest pending")
    `SHA1MD_NEVER(a_round_range, i_clk, i_rst_n, r_round > RoundLast, "round counter out of range")
    `SHA1MD_NEVER(a_index_range, i_clk, i_rst_n, r_idx > LastWord, "digest word index out of range")
    `SHA1MD_ASSERT(a_last_word_idle, i_clk, i_rst_n, (o_out_valid && i_out_ready && o_last_word) |=> o_in_ready, "no return to idle after digest")
    `SHA1MD_ASSERT(a_round_to_add, i_clk, i_rst_n, (r_state == S_ROUND && r_round == RoundLast) |=> (r_state == S_ADD), "rounds not followed by chain add")

endmodule

// File: design/sha1_message_digest_core.sv
// sha-1 digest core top level: controller and datapath
//
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------------
//  input    | i_in_valid  / o_in_ready    | i_data_byte, i_byte_present, i_end_of_message
//  output   | o_out_valid / i_out_ready   | o_digest_word, o_word_index, o_last_word
//
// a request that neither fills a block nor ends the message leaves the core idle; a byte
// that completes a 64-byte block runs rounds 0 to 79 on the single round unit, then the
// chaining add; end of message adds the padding bytes at one per cycle, one or two
// compressions, then the five digest words, each held until taken
// inputs are taken only when idle; a stalled output holds the whole core
// synchronous active-low reset loads the initial chaining words and clears the length
module sha1_message_digest_core
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd  cmd;
    t_stat stat;

    sha1md_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_byte_present   (i_byte_present),
        .i_end_of_message (i_end_of_message),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word),
        .i_stat           (stat),
        .o_cmd            (cmd)
    );

    sha1md_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_data_byte   (i_data_byte),
        .i_cmd         (cmd),
        .i_word_sel    (o_word_index),
        .o_stat        (stat),
        .o_digest_word (o_digest_word)
    );

endmodule
